/* rtl/pcsp_pkg.sv */
// Shared types, constants and command tables for the plot command stream parser.
// No dependencies; every other file in rtl/ except pcsp_ram uses this package.
package pcsp_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int OUT_COUNT_W = 32;
    localparam int NUM_CMDS    = 58;
    localparam int CMD_IDX_W   = 6;
    localparam int SKIP_W      = 6;

    localparam logic [7:0] FIRST_CMD = 8'h41;
    localparam logic [7:0] LINEFEED  = 8'h0A;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_CMD   = 2'd0,
        ST_ARG   = 2'd1,
        ST_BAD   = 2'd2,
        ST_REPLY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_BAD    = 2'd0,
        KIND_FIXED  = 2'd1,
        KIND_STRING = 2'd2
    } cmd_kind_t;

    // 'A' .. 'z'
    localparam cmd_kind_t CMD_KIND [NUM_CMDS] = '{
        KIND_BAD,   KIND_BAD,   KIND_FIXED, KIND_BAD,   KIND_BAD,
        KIND_FIXED, KIND_BAD,   KIND_BAD,   KIND_BAD,   KIND_BAD,
        KIND_BAD,   KIND_FIXED, KIND_FIXED, KIND_FIXED, KIND_FIXED,
        KIND_FIXED, KIND_FIXED, KIND_BAD,   KIND_FIXED, KIND_BAD,
        KIND_BAD,   KIND_FIXED, KIND_FIXED, KIND_FIXED, KIND_BAD,
        KIND_BAD,   KIND_BAD,   KIND_BAD,   KIND_BAD,   KIND_BAD,
        KIND_BAD,   KIND_BAD,   KIND_FIXED, KIND_BAD,   KIND_FIXED,
        KIND_BAD,   KIND_FIXED, KIND_STRING, KIND_BAD,  KIND_BAD,
        KIND_FIXED, KIND_BAD,   KIND_BAD,   KIND_FIXED, KIND_FIXED,
        KIND_FIXED, KIND_FIXED, KIND_FIXED, KIND_FIXED, KIND_FIXED,
        KIND_FIXED, KIND_STRING, KIND_BAD,  KIND_FIXED, KIND_FIXED,
        KIND_FIXED, KIND_BAD,   KIND_BAD
    };

    localparam logic [SKIP_W-1:0] CMD_BYTES [NUM_CMDS] = '{
        6'd0,  6'd0,  6'd3,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd12, 6'd6,  6'd6,  6'd24, 6'd6,  6'd24, 6'd0,  6'd12, 6'd0,
        6'd0,  6'd48, 6'd48, 6'd24, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd0,  6'd12, 6'd0,  6'd6,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd24, 6'd0,  6'd0,  6'd8,  6'd4,  6'd4,  6'd16, 6'd4,  6'd16, 6'd48,
        6'd8,  6'd0,  6'd0,  6'd32, 6'd32, 6'd16, 6'd0,  6'd0
    };

    typedef struct packed {
        logic                 en;
        logic [CMD_IDX_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        status_t              status;
        logic [7:0]           code;
        logic [SKIP_W-1:0]    remaining;
        logic                 in_string;
        logic [CMD_IDX_W-1:0] addr;
        logic                 hit;
        logic                 inc;
    } s1_t;

    function automatic logic [OUT_COUNT_W-1:0] count_out(input logic [COUNT_BITS-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        if (wide > 64'({OUT_COUNT_W{1'b1}}))
            return '1;
        return wide[OUT_COUNT_W-1:0];
    endfunction

endpackage

/* rtl/plot_command_stream_parser_top.sv */
// Top level of the plot command stream parser: handshakes, output register, packing.
// Depends on pcsp_pkg, pcsp_decode and pcsp_update.
//
// Usage:
//   Slave channel: one item per byte of the plot stream (s_axis_tuser = 0) or a
//   usage count read (s_axis_tuser = 1). Master channel: exactly one result item
//   per input item, in order, with its status in m_axis_tuser.
//   Path: each item passes the stage-1 register, then the output register.
//   Throughput: one item per cycle unless the output stalls. The counter RAM is
//   read in the accept cycle and written back as the item leaves stage 1; a command
//   that hits the entry just written takes the value from a forwarding register, so
//   no bubbles are needed.
//   Reset: stream state clears at once, and a valid bit per counter makes every
//   count read as zero until first written; items are taken right after reset.
//   Stall: while a result waits in the output register and m_axis_tready is low,
//   s_axis_tready is low and both stages hold; the two-stage pipe keeps
//   accepting as long as the output register empties in the same cycle.
module plot_command_stream_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // stream_byte[7:0], count_index[13:8], zero[15:14]
    input  logic        s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // command_code[7:0], bytes_remaining[13:8],
                                        // in_string_arg[14], count_value[46:15], zero[47]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    logic                                advance;
    logic                                accept;
    pcsp_pkg::rd_req_t                   rd;
    pcsp_pkg::s1_t                       s1;
    logic                                s1_valid;
    logic [pcsp_pkg::OUT_COUNT_W-1:0]    count_value;

    logic                                out_valid_reg;
    pcsp_pkg::status_t                   out_status_reg;
    logic [7:0]                          out_code_reg;
    logic [pcsp_pkg::SKIP_W-1:0]         out_remaining_reg;
    logic                                out_string_reg;
    logic [pcsp_pkg::OUT_COUNT_W-1:0]    out_count_reg;

    assign advance = !out_valid_reg || m_axis_tready;
    assign accept  = s_axis_tvalid && advance;

    pcsp_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .advance     (advance),
        .op          (s_axis_tuser),
        .stream_byte (s_axis_tdata[7:0]),
        .count_index (s_axis_tdata[13:8]),
        .rd          (rd),
        .s1          (s1),
        .s1_valid    (s1_valid)
    );

    pcsp_update u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .rd          (rd),
        .s1          (s1),
        .s1_valid    (s1_valid),
        .count_value (count_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid)
        begin
            out_status_reg    <= s1.status;
            out_code_reg      <= s1.code;
            out_remaining_reg <= s1.remaining;
            out_string_reg    <= s1.in_string;
            out_count_reg     <= count_value;
        end
    end

    assign s_axis_tready = advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = 2'(out_status_reg);
    assign m_axis_tdata  = {1'b0, out_count_reg, out_string_reg, out_remaining_reg, out_code_reg};

    a_bad_has_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == pcsp_pkg::ST_BAD) |->
        (out_count_reg == '0 && out_remaining_reg == '0 && !out_string_reg))
        else $error("bad command result carries argument or count data");

    a_cmd_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == pcsp_pkg::ST_CMD) |-> (out_count_reg != '0))
        else $error("accepted command reports a zero usage count");

    a_arg_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == pcsp_pkg::ST_ARG) |->
        !(out_remaining_reg != '0 && out_string_reg))
        else $error("argument result in fixed and string skip at once");

endmodule

/* rtl/pcsp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pcsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pcsp_decode.sv */
// Front stage: stream state, command table lookup and counter read request.
// Depends on pcsp_pkg.
module pcsp_decode (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             advance,
    input  logic                             op,
    input  logic [7:0]                       stream_byte,
    input  logic [pcsp_pkg::CMD_IDX_W-1:0]   count_index,
    output pcsp_pkg::rd_req_t                rd,
    output pcsp_pkg::s1_t                    s1,
    output logic                             s1_valid
);

    logic [pcsp_pkg::SKIP_W-1:0] skip_left_reg, skip_left_next;
    logic                        string_mode_reg, string_mode_next;
    logic [7:0]                  current_command_reg, current_command_next;
    logic                        s1_valid_reg;
    pcsp_pkg::s1_t               s1_reg, s1_next;

    logic [7:0]                  byte_off;
    logic [7:0]                  cur_off;
    logic                        byte_in_tbl;
    logic                        cur_in_tbl;
    pcsp_pkg::cmd_kind_t         kind;

    always_comb
    begin
        byte_off    = stream_byte - pcsp_pkg::FIRST_CMD;
        cur_off     = current_command_reg - pcsp_pkg::FIRST_CMD;
        byte_in_tbl = (stream_byte >= pcsp_pkg::FIRST_CMD) &&
                      (byte_off < 8'(pcsp_pkg::NUM_CMDS));
        cur_in_tbl  = (current_command_reg >= pcsp_pkg::FIRST_CMD) &&
                      (cur_off < 8'(pcsp_pkg::NUM_CMDS));
        kind        = byte_in_tbl ? pcsp_pkg::CMD_KIND[byte_off[pcsp_pkg::CMD_IDX_W-1:0]]
                                  : pcsp_pkg::KIND_BAD;

        skip_left_next       = skip_left_reg;
        string_mode_next     = string_mode_reg;
        current_command_next = current_command_reg;

        s1_next.status    = pcsp_pkg::ST_ARG;
        s1_next.code      = current_command_reg;
        s1_next.remaining = '0;
        s1_next.in_string = 1'b0;
        s1_next.addr      = cur_off[pcsp_pkg::CMD_IDX_W-1:0];
        s1_next.hit       = cur_in_tbl;
        s1_next.inc       = 1'b0;

        if (pcsp_pkg::op_t'(op) == pcsp_pkg::OP_READ)
        begin
            s1_next.status    = pcsp_pkg::ST_REPLY;
            s1_next.code      = pcsp_pkg::FIRST_CMD + 8'(count_index);
            s1_next.remaining = skip_left_reg;
            s1_next.in_string = string_mode_reg;
            s1_next.addr      = count_index;
            s1_next.hit       = count_index < pcsp_pkg::CMD_IDX_W'(pcsp_pkg::NUM_CMDS);
        end
        else if (skip_left_reg != '0)
        begin
            skip_left_next    = skip_left_reg - 1'b1;
            s1_next.remaining = skip_left_next;
        end
        else if (string_mode_reg)
        begin
            string_mode_next  = (stream_byte != pcsp_pkg::LINEFEED);
            s1_next.in_string = string_mode_next;
        end
        else if (kind == pcsp_pkg::KIND_BAD)
        begin
            s1_next.status = pcsp_pkg::ST_BAD;
            s1_next.code   = stream_byte;
            s1_next.hit    = 1'b0;
        end
        else
        begin
            current_command_next = stream_byte;
            if (kind == pcsp_pkg::KIND_STRING)
            begin
                string_mode_next = 1'b1;
                skip_left_next   = '0;
            end
            else
            begin
                string_mode_next = 1'b0;
                skip_left_next   = pcsp_pkg::CMD_BYTES[byte_off[pcsp_pkg::CMD_IDX_W-1:0]];
            end
            s1_next.status    = pcsp_pkg::ST_CMD;
            s1_next.code      = stream_byte;
            s1_next.remaining = skip_left_next;
            s1_next.in_string = string_mode_next;
            s1_next.addr      = byte_off[pcsp_pkg::CMD_IDX_W-1:0];
            s1_next.hit       = 1'b1;
            s1_next.inc       = 1'b1;
        end

        rd.en   = accept && s1_next.hit;
        rd.addr = s1_next.addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_left_reg       <= '0;
            string_mode_reg     <= 1'b0;
            current_command_reg <= '0;
            s1_valid_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                skip_left_reg       <= skip_left_next;
                string_mode_reg     <= string_mode_next;
                current_command_reg <= current_command_next;
            end
            if (advance)
                s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

    assign s1       = s1_reg;
    assign s1_valid = s1_valid_reg;

    a_skip_xor_string: assert property (@(posedge clk) disable iff (!rst_n)
        !(skip_left_reg != '0 && string_mode_reg))
        else $error("fixed skip and string skip active together");

    a_skip_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_left_reg != '0 || string_mode_reg) |-> cur_in_tbl)
        else $error("argument skip without a known command");

    a_reply_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pcsp_pkg::op_t'(op) == pcsp_pkg::OP_READ) |=>
        ($stable(skip_left_reg) && $stable(string_mode_reg) && $stable(current_command_reg)))
        else $error("count read changed stream state");

endmodule

/* rtl/pcsp_update.sv */
// Counter stage: usage count RAM, valid bits, write forwarding, saturating increment.
// Depends on pcsp_pkg and pcsp_ram.
module pcsp_update (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  pcsp_pkg::rd_req_t                   rd,
    input  pcsp_pkg::s1_t                       s1,
    input  logic                                s1_valid,
    output logic [pcsp_pkg::OUT_COUNT_W-1:0]    count_value
);

    logic [pcsp_pkg::NUM_CMDS-1:0]    valid_reg, valid_next;
    logic                             lw_valid_reg;
    logic [pcsp_pkg::CMD_IDX_W-1:0]   lw_addr_reg;
    logic [pcsp_pkg::COUNT_BITS-1:0]  lw_data_reg;

    logic [pcsp_pkg::COUNT_BITS-1:0]  rdata;
    logic [pcsp_pkg::COUNT_BITS-1:0]  cur;
    logic [pcsp_pkg::COUNT_BITS-1:0]  upd;
    logic                             wr_en;

    pcsp_ram #(
        .WIDTH (pcsp_pkg::COUNT_BITS),
        .DEPTH (pcsp_pkg::NUM_CMDS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1.addr),
        .wdata (upd),
        .re    (rd.en),
        .raddr (rd.addr),
        .rdata (rdata)
    );

    always_comb
    begin
        cur = '0;
        if (s1.hit)
        begin
            if (lw_valid_reg && lw_addr_reg == s1.addr)
                cur = lw_data_reg;
            else if (valid_reg[s1.addr])
                cur = rdata;
        end
        upd = (s1.inc && cur != pcsp_pkg::COUNT_MAX) ? cur + 1'b1 : cur;
        wr_en = advance && s1_valid && s1.inc;

        valid_next = valid_reg;
        if (wr_en)
            valid_next[s1.addr] = 1'b1;

        count_value = pcsp_pkg::count_out(upd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (wr_en)
                lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lw_addr_reg <= s1.addr;
            lw_data_reg <= upd;
        end
    end

endmodule
